// ----- rtl/jsu_pkg.sv -----
// Shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level; depends on nothing else.
`default_nettype none

package jsu_pkg;

  // Phase of the string parser in the front part.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX
  } phase_e;

  // What a queued job asks the back part to emit after the optional U+FFFD.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_RAW,
    JOB_CP,
    JOB_STATUS
  } job_kind_e;

  typedef logic [2:0] status_t;

  // Result status codes.
  localparam status_t ST_DATA       = 3'd0;
  localparam status_t ST_COMPLETE   = 3'd1;
  localparam status_t ST_NO_QUOTE   = 3'd2;
  localparam status_t ST_BAD_ESC    = 3'd3;
  localparam status_t ST_BAD_HEX    = 3'd4;
  localparam status_t ST_UNTERMINAT = 3'd5;

  // Code point constants.
  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP    = 21'h010000;

  // One decoded step: an optional replacement character, then one main item.
  typedef struct packed {
    logic        flush;
    job_kind_e   kind;
    logic [20:0] value;
    status_t     status;
  } job_t;

  // Job queue between the front and back parts; depth is a power of two.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Front part: parses one text byte per request and turns it into a job.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire  [7:0]        in_byte_i,
  input  wire               q_full_i,
  output logic              in_stall_o,
  output logic              job_valid_o,
  output jsu_pkg::job_t     job_o
);
  import jsu_pkg::*;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [11:0] acc_q, acc_d;
  logic [9:0]  high_q, high_d;
  logic        pend_q, pend_d;

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic        hex_flush;
  logic [15:0] cp16;
  job_t        job;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Hex digit decode of the incoming byte.
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_v = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_v = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_v = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp16 = {acc_q, hex_v};

  // A held high surrogate is dropped when the next escape cannot be a low surrogate.
  assign hex_flush = pend_q && ((cnt_q == 2'd0 && hex_v != 4'hD) ||
                                (cnt_q == 2'd1 && hex_v < 4'hC));

  // Next state and job for the byte at the input.
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    high_d     = high_q;
    pend_d     = pend_q;
    job.flush  = 1'b0;
    job.kind   = JOB_NONE;
    job.value  = '0;
    job.status = ST_DATA;
    unique case (phase_q)
      PH_IDLE: begin
        cnt_d  = '0;
        acc_d  = '0;
        high_d = '0;
        pend_d = 1'b0;
        if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_BODY;
        end else begin
          phase_d    = PH_IDLE;
          job.kind   = JOB_STATUS;
          job.status = ST_NO_QUOTE;
        end
      end
      PH_BODY: begin
        if (in_byte_i == CH_BSL) begin
          phase_d = PH_ESC;
        end else begin
          job.flush = pend_q;
          pend_d    = 1'b0;
          high_d    = '0;
          if (in_byte_i == CH_NUL || in_byte_i == CH_QUOTE) begin
            phase_d    = PH_IDLE;
            cnt_d      = '0;
            acc_d      = '0;
            job.kind   = JOB_STATUS;
            job.status = (in_byte_i == CH_NUL) ? ST_UNTERMINAT : ST_COMPLETE;
          end else begin
            job.kind  = JOB_RAW;
            job.value = {13'd0, in_byte_i};
          end
        end
      end
      PH_ESC: begin
        if (in_byte_i == CH_U) begin
          phase_d = PH_HEX;
          cnt_d   = '0;
          acc_d   = '0;
        end else begin
          job.flush = pend_q;
          pend_d    = 1'b0;
          high_d    = '0;
          phase_d   = PH_BODY;
          job.kind  = JOB_CP;
          unique case (in_byte_i)
            CH_QUOTE: job.value = 21'h22;
            CH_BSL:   job.value = 21'h5C;
            CH_SLASH: job.value = 21'h2F;
            CH_B:     job.value = 21'h08;
            CH_F:     job.value = 21'h0C;
            CH_N:     job.value = 21'h0A;
            CH_R:     job.value = 21'h0D;
            CH_T:     job.value = 21'h09;
            default: begin
              phase_d    = PH_IDLE;
              cnt_d      = '0;
              acc_d      = '0;
              job.kind   = JOB_STATUS;
              job.status = ST_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (!hex_ok) begin
          job.flush  = pend_q;
          job.kind   = JOB_STATUS;
          job.status = ST_BAD_HEX;
          phase_d    = PH_IDLE;
          cnt_d      = '0;
          acc_d      = '0;
          high_d     = '0;
          pend_d     = 1'b0;
        end else begin
          job.flush = hex_flush;
          if (hex_flush) begin
            pend_d = 1'b0;
            high_d = '0;
          end
          if (cnt_q == 2'd3) begin
            // Fourth digit: the code point is complete.
            phase_d = PH_BODY;
            cnt_d   = '0;
            acc_d   = '0;
            pend_d  = 1'b0;
            high_d  = '0;
            if (pend_q && !hex_flush) begin
              job.kind  = JOB_CP;
              job.value = CP_SUPP + {1'b0, high_q, cp16[9:0]};
            end else if (cp16[15:10] == 6'b110110) begin
              pend_d = 1'b1;
              high_d = cp16[9:0];
            end else if (cp16[15:10] == 6'b110111) begin
              job.kind  = JOB_CP;
              job.value = CP_REPLACE;
            end else begin
              job.kind  = JOB_CP;
              job.value = {5'd0, cp16};
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
            acc_d = cp16[11:0];
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign job_o       = job;
  assign job_valid_o = accept && (job.flush || job.kind != JOB_NONE);

  // Parser state registers, advanced on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      high_q  <= '0;
      pend_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      high_q  <= high_d;
      pend_q  <= pend_d;
    end
  end

  // A held surrogate only lives inside a string, and digits are counted only in an escape.
  a_pend_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q == PH_BODY || phase_q == PH_ESC || phase_q == PH_HEX))
    else $error("surrogate held outside a string");
  a_cnt_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (phase_q == PH_HEX))
    else $error("hex digit count outside a hex escape");

endmodule

`default_nettype wire

// ----- rtl/jsu_queue.sv -----
// Short job queue that decouples the front part from the back part.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  jsu_pkg::job_t     push_job_i,
  output logic              full_o,
  output logic              valid_o,
  output jsu_pkg::job_t     head_o,
  input  wire               pop_i
);
  import jsu_pkg::*;

  job_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Back part: expands the head job into result bytes, one per cycle while not stalled, into an output register.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               job_valid_i,
  input  jsu_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        status_o,
  output logic              last_o
);
  import jsu_pkg::*;

  // Byte i of the UTF-8 form of a code point whose encoded length is len.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (i == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (i)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (i)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  status_t    status_q;
  logic       last_q;

  logic [2:0] cp_len;
  logic [2:0] n_flush;
  logic [2:0] n_main;
  logic [2:0] n_res;
  logic [1:0] main_idx;
  logic       advance;
  logic       res_last;
  logic [7:0] res_byte;
  status_t    res_status;

  // Result count of the head job.
  always_comb begin
    if (job_i.value < 21'h80) begin
      cp_len = 3'd1;
    end else if (job_i.value < 21'h800) begin
      cp_len = 3'd2;
    end else if (job_i.value < 21'h10000) begin
      cp_len = 3'd3;
    end else begin
      cp_len = 3'd4;
    end
    n_flush = job_i.flush ? 3'd3 : 3'd0;
    unique case (job_i.kind)
      JOB_RAW, JOB_STATUS: n_main = 3'd1;
      JOB_CP:              n_main = cp_len;
      default:             n_main = 3'd0;
    endcase
    n_res = n_flush + n_main;
  end

  // The result at the current position of the head job.
  always_comb begin
    main_idx   = idx_q - n_flush[1:0];
    res_status = ST_DATA;
    if ({1'b0, idx_q} < n_flush) begin
      res_byte = utf8_byte(CP_REPLACE, 3'd3, idx_q);
    end else begin
      unique case (job_i.kind)
        JOB_RAW: res_byte = job_i.value[7:0];
        JOB_CP:  res_byte = utf8_byte(job_i.value, cp_len, main_idx);
        default: begin
          res_byte   = 8'h00;
          res_status = job_i.status;
        end
      endcase
    end
    res_last = ({1'b0, idx_q} + 3'd1 >= n_res);
  end

  assign advance = job_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = advance && res_last;

  // Position within the head job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (advance) begin
      idx_q <= res_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Output register: loads a new result when empty or when its result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q   <= res_byte;
      status_q <= res_status;
      last_q   <= res_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // A job being expanded stays at the head, and every queued job yields a result.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> job_valid_i)
    else $error("head job vanished while being expanded");
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (n_res != 3'd0 && n_res <= 3'd4))
    else $error("queued job with no or too many results");

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8_core.sv -----
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   in_byte_i
//   output   out        out_valid_o / out_stall_i out_byte_o, status_o, last_o
//
// A text byte is parsed in the cycle it is accepted; one byte per cycle is taken
// while the four-entry job queue has room.
// The back part emits one result per cycle while out_stall_i is low, and a byte yields
// up to four results (a replacement character plus one more).
// A result passes the job queue and the output register after its byte is accepted.
// Reset is asynchronous and active low; it returns the parser to waiting for the
// opening quote and empties the queue and the output register.
`default_nettype none

module json_string_unescape_utf8_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] in_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .valid_o    (head_valid),
    .head_o     (head_job),
    .pop_i      (pop)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
